FILE: sv/hgf_pkg.sv
// shared types, constants and tap arithmetic for the height grid 3x3 filter
// no dependencies; every other file but hgf_ram imports this package
package hgf_pkg;

    // grid and sample limits
    localparam int MAX_COLS     = 1024;
    localparam int MAX_ROWS     = 1024;
    localparam int SAMPLE_BITS  = 16;

    // field widths of the configuration port
    localparam int DIM_BITS     = 11;
    localparam int KSEL_BITS    = 3;
    localparam int REG_IDX_BITS = 2;

    // derived counter widths
    localparam int COL_BITS     = $clog2(MAX_COLS);
    localparam int ROW_BITS     = $clog2(MAX_ROWS);
    localparam int IN_ROW_BITS  = $clog2(MAX_ROWS + 3);
    localparam int FILL_BITS    = $clog2(MAX_COLS + 2);

    // accumulator holds up to 1024 times a full-scale sample; tap weights sum to at most 272
    localparam int ACC_BITS     = SAMPLE_BITS + 10;
    localparam int FRAC_SHIFT   = 4;

    // register indexes
    localparam logic [REG_IDX_BITS-1:0] REG_KERNEL = REG_IDX_BITS'(0);
    localparam logic [REG_IDX_BITS-1:0] REG_COLS   = REG_IDX_BITS'(1);
    localparam logic [REG_IDX_BITS-1:0] REG_ROWS   = REG_IDX_BITS'(2);

    // reset value of both grid dimensions
    localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(1024);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [ACC_BITS-1:0]    t_acc;
    typedef logic [DIM_BITS-1:0]           t_dim;
    typedef t_sample                       t_window [3][3];

    localparam t_acc ROUND_HALF = t_acc'(2 ** (FRAC_SHIFT - 1));
    localparam t_acc SAT_MAX    = t_acc'((longint'(1) <<< (SAMPLE_BITS - 1)) - 1);
    localparam t_acc SAT_MIN    = t_acc'(-(longint'(1) <<< (SAMPLE_BITS - 1)));

    typedef enum logic [KSEL_BITS-1:0] {
        K_GAUSS = 3'd0,
        K_DIAG  = 3'd1,
        K_LAPL  = 3'd2,
        K_SHARP = 3'd3,
        K_ZERO  = 3'd4
    } t_kernel;

    // tap weights in 1/16 units
    typedef enum logic [2:0] {
        W_ZERO,
        W_P1,
        W_P2,
        W_P4,
        W_P16,
        W_N16,
        W_N48,
        W_P144
    } t_weight;

    localparam t_weight KERNEL_TAB [5][9] = '{
        '{W_P1,   W_P2,   W_P1,   W_P2,   W_P4,   W_P2,   W_P1,   W_P2,   W_P1},
        '{W_P16,  W_ZERO, W_N16,  W_ZERO, W_P16,  W_ZERO, W_N16,  W_ZERO, W_P16},
        '{W_ZERO, W_P16,  W_ZERO, W_P16,  W_N48,  W_P16,  W_ZERO, W_P16,  W_ZERO},
        '{W_N16,  W_N16,  W_N16,  W_N16,  W_P144, W_N16,  W_N16,  W_N16,  W_N16},
        '{W_ZERO, W_ZERO, W_ZERO, W_ZERO, W_ZERO, W_ZERO, W_ZERO, W_ZERO, W_ZERO}
    };

    typedef struct packed {
        t_kernel kernel;
        t_dim    cols;
        t_dim    rows;
    } t_cfg;

    // per-item tag: result flag, window edge validity, end of frame
    typedef struct packed {
        logic emit;
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
        logic last;
    } t_tag;

    // sample times weight, built from shifts and adds
    function automatic t_acc tap_term(input t_sample s, input t_weight w);
        t_acc x;
        t_acc p;
        x = t_acc'(s);
        unique case (w)
            W_ZERO:  p = '0;
            W_P1:    p = x;
            W_P2:    p = x <<< 1;
            W_P4:    p = x <<< 2;
            W_P16:   p = x <<< 4;
            W_N16:   p = -(x <<< 4);
            W_N48:   p = -((x <<< 5) + (x <<< 4));
            W_P144:  p = (x <<< 7) + (x <<< 4);
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

FILE: sv/hgf_if.sv
// channel interfaces: sample items in, filtered items out, register writes
// depends on hgf_pkg for payload types
interface hgf_in_if;
    import hgf_pkg::*;
    logic    valid;
    logic    ready;
    logic    mode;
    t_sample height_in;
    modport source (output valid, mode, height_in, input ready);
    modport sink   (input valid, mode, height_in, output ready);
endinterface

interface hgf_out_if;
    import hgf_pkg::*;
    logic    valid;
    logic    ready;
    t_sample height_out;
    logic    saturated;
    logic    frame_last;
    modport source (output valid, height_out, saturated, frame_last, input ready);
    modport sink   (input valid, height_out, saturated, frame_last, output ready);
endinterface

interface hgf_cfg_if;
    import hgf_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [REG_IDX_BITS-1:0] index;
    logic [DIM_BITS-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/hgf_ram.sv
// generic simple dual-port ram: one write port, one registered read port
// no package dependency; read during write to the same address returns old data
module hgf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

FILE: sv/hgf_cfg_regs.sv
// configuration registers: kernel select and grid dimensions
// depends on hgf_pkg and hgf_cfg_if; dimension writes restart the frame
module hgf_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hgf_cfg_if.sink       i_cfg,
    output hgf_pkg::t_cfg o_cfg,
    output logic          o_restart
);
    import hgf_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic w_wr;

    // zero acts as one, above the limit acts as the limit
    function automatic t_dim clamp_dim(input t_dim v, input int max_v);
        t_dim d;
        if (v == '0) begin
            d = t_dim'(1);
        end else if (int'(v) > max_v) begin
            d = t_dim'(max_v);
        end else begin
            d = v;
        end
        return d;
    endfunction

    assign i_cfg.ready = 1'b1;
    assign w_wr        = i_cfg.valid;

    // register update
    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (i_cfg.index)
                REG_KERNEL: begin
                    if (i_cfg.data[KSEL_BITS-1:0] > KSEL_BITS'(K_ZERO)) begin
                        n_cfg.kernel = K_ZERO;
                    end else begin
                        n_cfg.kernel = t_kernel'(i_cfg.data[KSEL_BITS-1:0]);
                    end
                end
                REG_COLS: n_cfg.cols = clamp_dim(i_cfg.data, MAX_COLS);
                REG_ROWS: n_cfg.rows = clamp_dim(i_cfg.data, MAX_ROWS);
                default:  n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kernel <= K_GAUSS;
            r_cfg.cols   <= clamp_dim(DIM_RESET, MAX_COLS);
            r_cfg.rows   <= clamp_dim(DIM_RESET, MAX_ROWS);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg     = r_cfg;
    assign o_restart = w_wr && (i_cfg.index == REG_COLS || i_cfg.index == REG_ROWS);

endmodule

FILE: sv/hgf_seq.sv
// raster position tracking: input column/row, warm-up count, output position
// depends on hgf_pkg; tags each accepted item with its result and edge flags
module hgf_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hgf_pkg::t_cfg                i_cfg,
    input  logic                         i_restart,
    input  logic                         i_accept,
    input  logic                         i_mode,
    input  hgf_pkg::t_sample             i_height,
    output logic                         o_used,
    output logic [hgf_pkg::COL_BITS-1:0] o_addr,
    output hgf_pkg::t_sample             o_sample,
    output hgf_pkg::t_tag                o_tag
);
    import hgf_pkg::*;

    logic [COL_BITS-1:0]    r_in_col;
    logic [COL_BITS-1:0]    n_in_col;
    logic [IN_ROW_BITS-1:0] r_in_row;
    logic [IN_ROW_BITS-1:0] n_in_row;
    logic [FILL_BITS-1:0]   r_fill;
    logic [FILL_BITS-1:0]   n_fill;
    logic [COL_BITS-1:0]    r_ocol;
    logic [COL_BITS-1:0]    n_ocol;
    logic [ROW_BITS-1:0]    r_orow;
    logic [ROW_BITS-1:0]    n_orow;
    logic                   w_has_data;
    logic                   w_col_wrap;
    logic                   w_step;
    t_tag                   w_tag;

    // item classification and tag
    always_comb begin
        w_has_data     = 32'(r_in_row) < 32'(i_cfg.rows);
        w_col_wrap     = 32'(r_in_col) + 32'd1 >= 32'(i_cfg.cols);
        w_tag.emit     = 32'(r_fill) == 32'(i_cfg.cols) + 32'd1;
        w_tag.top_ok   = r_orow != '0;
        w_tag.bot_ok   = 32'(r_orow) + 32'd1 < 32'(i_cfg.rows);
        w_tag.left_ok  = r_ocol != '0;
        w_tag.right_ok = 32'(r_ocol) + 32'd1 < 32'(i_cfg.cols);
        w_tag.last     = !w_tag.right_ok && !w_tag.bot_ok;
    end

    // early drain ticks are dropped, late samples count as drain
    assign o_used   = !(i_mode && w_has_data);
    assign o_addr   = r_in_col;
    assign o_sample = w_has_data ? i_height : '0;
    assign o_tag    = w_tag;
    assign w_step   = i_accept && o_used;

    // counter next state
    always_comb begin
        n_in_col = r_in_col;
        n_in_row = r_in_row;
        n_fill   = r_fill;
        n_ocol   = r_ocol;
        n_orow   = r_orow;
        if (i_restart) begin
            n_in_col = '0;
            n_in_row = '0;
            n_fill   = '0;
            n_ocol   = '0;
            n_orow   = '0;
        end else if (w_step) begin
            if (w_col_wrap) begin
                n_in_col = '0;
                n_in_row = r_in_row + IN_ROW_BITS'(1);
            end else begin
                n_in_col = r_in_col + COL_BITS'(1);
            end
            if (!w_tag.emit) begin
                n_fill = r_fill + FILL_BITS'(1);
            end else if (w_tag.last) begin
                n_in_col = '0;
                n_in_row = '0;
                n_fill   = '0;
                n_ocol   = '0;
                n_orow   = '0;
            end else if (w_tag.right_ok) begin
                n_ocol = r_ocol + COL_BITS'(1);
            end else begin
                n_ocol = '0;
                n_orow = r_orow + ROW_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col <= '0;
            r_in_row <= '0;
            r_fill   <= '0;
            r_ocol   <= '0;
            r_orow   <= '0;
        end else begin
            r_in_col <= n_in_col;
            r_in_row <= n_in_row;
            r_fill   <= n_fill;
            r_ocol   <= n_ocol;
            r_orow   <= n_orow;
        end
    end

    // the frame's last result returns every position counter to zero
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && w_tag.emit && w_tag.last |=>
            r_in_col == '0 && r_in_row == '0 && r_fill == '0 &&
            r_ocol == '0 && r_orow == '0)
        else $error("position counters not cleared after frame end");

    // column positions stay inside the configured row length
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ocol) < 32'(i_cfg.cols) && 32'(r_in_col) < 32'(i_cfg.cols))
        else $error("column position beyond grid width");

endmodule

FILE: sv/hgf_line_buf.sv
// two line rams plus the 3x3 window; stage 1 reads the rams, stage 2 holds the window
// depends on hgf_pkg and hgf_ram; forwards the previous write when the address repeats
module hgf_line_buf (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic [hgf_pkg::COL_BITS-1:0] i_addr,
    input  hgf_pkg::t_sample             i_sample,
    input  hgf_pkg::t_tag                i_tag,
    input  logic                         i_s3_free,
    output logic                         o_ready,
    output hgf_pkg::t_window             o_window,
    output logic                         o_s2_valid,
    output hgf_pkg::t_tag                o_s2_tag
);
    import hgf_pkg::*;

    logic                r_s1_v;
    logic [COL_BITS-1:0] r_s1_addr;
    t_sample             r_s1_sample;
    t_tag                r_s1_tag;
    logic                r_byp;
    t_sample             r_fwd_mid;
    t_sample             r_fwd_top;
    logic                r_s2_v;
    t_tag                r_s2_tag;
    t_window             r_win;
    logic                w_en1;
    logic                w_en2;
    logic                w_we;
    logic [SAMPLE_BITS-1:0] w_q0;
    logic [SAMPLE_BITS-1:0] w_q1;
    t_sample             w_mid;
    t_sample             w_top;

    // stage enables
    assign w_en2   = !r_s2_v || i_s3_free;
    assign w_en1   = !r_s1_v || w_en2;
    assign w_we    = r_s1_v && w_en2;
    assign o_ready = w_en1;

    // previous-row and two-rows-back samples, forwarded on repeat address
    assign w_mid = r_byp ? r_fwd_mid : t_sample'(w_q0);
    assign w_top = r_byp ? r_fwd_top : t_sample'(w_q1);

    // line ram for the previous row
    hgf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_COLS)
    ) u_ram_mid (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_s1_addr),
        .i_wdata (r_s1_sample),
        .i_re    (i_load),
        .i_raddr (i_addr),
        .o_rdata (w_q0)
    );

    // line ram for the row before that
    hgf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_COLS)
    ) u_ram_top (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_s1_addr),
        .i_wdata (w_mid),
        .i_re    (i_load),
        .i_raddr (i_addr),
        .o_rdata (w_q1)
    );

    // stage valids and forwarding flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_byp  <= 1'b0;
        end else begin
            if (w_en1) begin
                r_s1_v <= i_load;
            end
            if (w_en2) begin
                r_s2_v <= r_s1_v && r_s1_tag.emit;
            end
            if (i_load) begin
                r_byp <= w_we && (r_s1_addr == i_addr);
            end
        end
    end

    // stage 1 payload and forward data
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1_addr   <= i_addr;
            r_s1_sample <= i_sample;
            r_s1_tag    <= i_tag;
            r_fwd_mid   <= r_s1_sample;
            r_fwd_top   <= w_mid;
        end
    end

    // window shift as an item leaves stage 1
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= w_top;
            r_win[1][2] <= w_mid;
            r_win[2][2] <= r_s1_sample;
            r_s2_tag    <= r_s1_tag;
        end
    end

    assign o_window   = r_win;
    assign o_s2_valid = r_s2_v;
    assign o_s2_tag   = r_s2_tag;

    // a new item enters stage 1 only as the previous one writes back
    a_s1_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load && r_s1_v |-> w_we)
        else $error("stage 1 overwritten before write-back");

    // forwarding is only armed by a write at the load edge
    a_byp_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_load) && r_byp |-> $past(w_we))
        else $error("forwarding flag set without a write");

endmodule

FILE: sv/hgf_mac.sv
// weighted sum: stage 3 forms row sums, output register rounds and saturates
// depends on hgf_pkg and hgf_out_if
module hgf_mac (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hgf_pkg::t_kernel  i_kernel,
    input  hgf_pkg::t_window  i_window,
    input  logic              i_s2_valid,
    input  hgf_pkg::t_tag     i_s2_tag,
    output logic              o_s3_free,
    hgf_out_if.source         o_result
);
    import hgf_pkg::*;

    logic    r_s3_v;
    logic    r_s3_last;
    t_acc    r_row_sum [3];
    logic    r_out_v;
    t_sample r_out_h;
    logic    r_out_sat;
    logic    r_out_last;
    logic    w_en_out;
    logic    w_en3;
    logic    w_row_ok [3];
    logic    w_col_ok [3];
    t_sample w_pick [3][3];
    t_acc    w_term [3][3];
    t_acc    w_row [3];
    t_acc    w_total;
    t_acc    w_q;
    t_sample w_h;
    logic    w_sat;

    assign w_en_out  = !r_out_v || o_result.ready;
    assign w_en3     = !r_s3_v || w_en_out;
    assign o_s3_free = w_en3;

    // neighbors off the grid take the center sample, then weight each tap
    always_comb begin
        w_row_ok[0] = i_s2_tag.top_ok;
        w_row_ok[1] = 1'b1;
        w_row_ok[2] = i_s2_tag.bot_ok;
        w_col_ok[0] = i_s2_tag.left_ok;
        w_col_ok[1] = 1'b1;
        w_col_ok[2] = i_s2_tag.right_ok;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                w_pick[r][c] = (w_row_ok[r] && w_col_ok[c]) ? i_window[r][c] : i_window[1][1];
                w_term[r][c] = tap_term(w_pick[r][c], KERNEL_TAB[i_kernel][r*3+c]);
            end
            w_row[r] = w_term[r][0] + w_term[r][1] + w_term[r][2];
        end
    end

    // final sum, round half up, clip to sample range
    always_comb begin
        w_total = r_row_sum[0] + r_row_sum[1] + r_row_sum[2] + ROUND_HALF;
        w_q     = w_total >>> FRAC_SHIFT;
        w_sat   = 1'b0;
        if (w_q > SAT_MAX) begin
            w_h   = t_sample'(SAT_MAX);
            w_sat = 1'b1;
        end else if (w_q < SAT_MIN) begin
            w_h   = t_sample'(SAT_MIN);
            w_sat = 1'b1;
        end else begin
            w_h = t_sample'(w_q);
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_en3) begin
                r_s3_v <= i_s2_valid;
            end
            if (w_en_out) begin
                r_out_v <= r_s3_v;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_row_sum <= w_row;
            r_s3_last <= i_s2_tag.last;
        end
        if (w_en_out) begin
            r_out_h    <= w_h;
            r_out_sat  <= w_sat;
            r_out_last <= r_s3_last;
        end
    end

    assign o_result.valid      = r_out_v;
    assign o_result.height_out = r_out_h;
    assign o_result.saturated  = r_out_sat;
    assign o_result.frame_last = r_out_last;

    // a clipped result sits at one of the range limits
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out_sat |->
            (r_out_h == t_sample'(SAT_MAX) || r_out_h == t_sample'(SAT_MIN)))
        else $error("saturated flag with in-range value");

    // a result in stage 3 is kept while the output register is blocked
    a_s3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_v && !w_en_out |=> r_s3_v)
        else $error("stage 3 result dropped under stall");

endmodule

FILE: sv/height_grid_3x3_filter.sv
// 3x3 height grid filter: accepts one item per cycle while results are taken,
// limited by one read and one write per line ram each cycle; after grid_cols + 1
// fill items, each completing item's result passes stages 1-3 and output register
// reset (synchronous, active low) clears pipeline valids, position counters and
// configuration; line rams are not cleared and need no clearing pass
// depends on hgf_pkg, hgf_if, hgf_cfg_regs, hgf_seq, hgf_line_buf, hgf_mac
module height_grid_3x3_filter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hgf_in_if.sink     i_item,
    hgf_out_if.source  o_result,
    hgf_cfg_if.sink    i_cfg
);
    import hgf_pkg::*;

    t_cfg                w_cfg;
    logic                w_restart;
    logic                w_accept;
    logic                w_used;
    logic                w_load;
    logic                w_ready;
    logic [COL_BITS-1:0] w_addr;
    t_sample             w_sample;
    t_tag                w_tag;
    logic                w_s3_free;
    t_window             w_window;
    logic                w_s2_valid;
    t_tag                w_s2_tag;

    // input handshake
    assign i_item.ready = w_ready;
    assign w_accept     = i_item.valid && w_ready;
    assign w_load       = w_accept && w_used;

    // configuration registers
    hgf_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .o_cfg     (w_cfg),
        .o_restart (w_restart)
    );

    // raster position and item tagging
    hgf_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_restart (w_restart),
        .i_accept  (w_accept),
        .i_mode    (i_item.mode),
        .i_height  (i_item.height_in),
        .o_used    (w_used),
        .o_addr    (w_addr),
        .o_sample  (w_sample),
        .o_tag     (w_tag)
    );

    // line rams and window
    hgf_line_buf u_lbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_addr     (w_addr),
        .i_sample   (w_sample),
        .i_tag      (w_tag),
        .i_s3_free  (w_s3_free),
        .o_ready    (w_ready),
        .o_window   (w_window),
        .o_s2_valid (w_s2_valid),
        .o_s2_tag   (w_s2_tag)
    );

    // weighted sum and output register
    hgf_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_kernel   (w_cfg.kernel),
        .i_window   (w_window),
        .i_s2_valid (w_s2_valid),
        .i_s2_tag   (w_s2_tag),
        .o_s3_free  (w_s3_free),
        .o_result   (o_result)
    );

endmodule
